@@ rtl/core/assert_macros.svh @@
// Assertion macros for the checker file of the core.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/lru_kv_pkg.sv @@
// Package for the LRU key-value cache: sizes, codes and the structs passed
// between the store, the scan unit and the sequencer. No dependencies.
package lru_kv_pkg;

  localparam int ENTRIES = 8;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W  = IDX_W;
  localparam int OCC_W   = $clog2(ENTRIES + 1);
  localparam int CAP_W   = 4;
  localparam int CMP_W   = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam int DATA_W  = 32;

  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(ENTRIES - 1);
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(8);

  typedef enum logic {
    CMD_GET,
    CMD_PUT
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WB,
    S_OUT
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
    logic [RANK_W-1:0] rank;
  } entry_t;

  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic [RANK_W-1:0] hit_rank;
    logic [DATA_W-1:0] hit_value;
    logic              old_found;
    logic [IDX_W-1:0]  old_idx;
    logic [RANK_W-1:0] old_rank;
    logic [DATA_W-1:0] old_key;
    logic              free_found;
    logic [IDX_W-1:0]  free_idx;
  } scan_t;

  typedef struct packed {
    logic              en;
    logic              insert;
    logic              wr_value;
    logic              occ_inc;
    logic [IDX_W-1:0]  slot;
    logic [RANK_W-1:0] old_rank;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
  } wb_t;

  typedef struct packed {
    logic              found;
    logic [DATA_W-1:0] read_value;
    logic              evicted;
    logic [DATA_W-1:0] evicted_key;
  } result_t;

endpackage

@@ rtl/core/lru_kv_if.sv @@
// Handshake interfaces for the input, result and configuration channels.
// Depends on lru_kv_pkg.
interface lru_kv_in_if;
  logic                                valid;
  logic                                ready;
  logic                                cmd;
  logic signed [lru_kv_pkg::DATA_W-1:0] key;
  logic signed [lru_kv_pkg::DATA_W-1:0] value;
  modport source (output valid, cmd, key, value, input ready);
  modport sink   (input valid, cmd, key, value, output ready);
endinterface

interface lru_kv_out_if;
  logic                                valid;
  logic                                ready;
  logic                                found;
  logic signed [lru_kv_pkg::DATA_W-1:0] read_value;
  logic                                evicted;
  logic signed [lru_kv_pkg::DATA_W-1:0] evicted_key;
  modport source (output valid, found, read_value, evicted, evicted_key, input ready);
  modport sink   (input valid, found, read_value, evicted, evicted_key, output ready);
endinterface

interface lru_kv_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lru_kv_pkg::CAP_W-1:0]   data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ rtl/core/lru_kv_store.sv @@
// Entry store: keys, values, ranks, valid bits and occupancy, one read port
// at the scan index and a synchronous write-back port. Depends on lru_kv_pkg.
module lru_kv_store (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [lru_kv_pkg::IDX_W-1:0]    rd_idx,
  output lru_kv_pkg::entry_t              rd,
  input  lru_kv_pkg::wb_t                 wb,
  output logic [lru_kv_pkg::OCC_W-1:0]    occ
);

  logic [lru_kv_pkg::DATA_W-1:0] key_r   [lru_kv_pkg::ENTRIES];
  logic [lru_kv_pkg::DATA_W-1:0] value_r [lru_kv_pkg::ENTRIES];
  logic [lru_kv_pkg::RANK_W-1:0] rank_r  [lru_kv_pkg::ENTRIES];
  logic [lru_kv_pkg::ENTRIES-1:0] valid_r;
  logic [lru_kv_pkg::OCC_W-1:0]   occ_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
    end else if (wb.en) begin
      valid_r[wb.slot] <= 1'b1;
      if (wb.occ_inc) begin
        occ_r <= occ_r + lru_kv_pkg::OCC_W'(1);
      end
    end
  end

  // target slot becomes most recent; younger valid entries age by one, every other valid entry on an insert
  always_ff @(posedge clk) begin
    if (wb.en) begin
      for (int i = 0; i < lru_kv_pkg::ENTRIES; i++) begin
        if (lru_kv_pkg::IDX_W'(i) == wb.slot) begin
          key_r[i]  <= wb.key;
          rank_r[i] <= '0;
          if (wb.wr_value) begin
            value_r[i] <= wb.value;
          end
        end else if (valid_r[i] && (wb.insert || rank_r[i] < wb.old_rank)) begin
          rank_r[i] <= rank_r[i] + lru_kv_pkg::RANK_W'(1);
        end
      end
    end
  end

  always_comb begin
    rd.valid = valid_r[rd_idx];
    rd.key   = key_r[rd_idx];
    rd.value = value_r[rd_idx];
    rd.rank  = rank_r[rd_idx];
  end

  assign occ = occ_r;

endmodule

@@ rtl/core/lru_kv_scan.sv @@
// Shared scan unit: one entry a cycle, key match, least recent and first
// free slot tracked in registers. Depends on lru_kv_pkg.
module lru_kv_scan (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            clear,
  input  logic                            step,
  input  logic [lru_kv_pkg::IDX_W-1:0]    idx,
  input  logic [lru_kv_pkg::DATA_W-1:0]   key,
  input  lru_kv_pkg::entry_t              rd,
  output lru_kv_pkg::scan_t               res
);

  lru_kv_pkg::scan_t res_r;
  lru_kv_pkg::scan_t res_nxt;

  always_comb begin
    res_nxt = res_r;
    if (clear) begin
      res_nxt.hit        = 1'b0;
      res_nxt.old_found  = 1'b0;
      res_nxt.free_found = 1'b0;
    end else if (step) begin
      if (rd.valid && !res_r.hit && rd.key == key) begin
        res_nxt.hit       = 1'b1;
        res_nxt.hit_idx   = idx;
        res_nxt.hit_rank  = rd.rank;
        res_nxt.hit_value = rd.value;
      end
      // strictly older only: lowest index wins a tie
      if (rd.valid && (!res_r.old_found || rd.rank > res_r.old_rank)) begin
        res_nxt.old_found = 1'b1;
        res_nxt.old_idx   = idx;
        res_nxt.old_rank  = rd.rank;
        res_nxt.old_key   = rd.key;
      end
      if (!rd.valid && !res_r.free_found) begin
        res_nxt.free_found = 1'b1;
        res_nxt.free_idx   = idx;
      end
    end
  end

  // only the flags are reset; the captured fields follow them
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (!rst_n) begin
      res_r.hit        <= 1'b0;
      res_r.old_found  <= 1'b0;
      res_r.free_found <= 1'b0;
    end
  end

  assign res = res_r;

endmodule

@@ rtl/core/lru_key_value_cache.sv @@
// Top level of the LRU key-value cache: sequencer, capacity register and
// result register. Depends on lru_kv_pkg, lru_kv_if, lru_kv_store, lru_kv_scan.
//
//   channel  dir  word                                   handshake
//   in_ch    in   cmd, key, value                        valid/ready
//   out_ch   out  found, read_value, evicted, evicted_key valid/ready
//   cfg_ch   in   data (capacity_in_use)                 valid/ready, ready tied high
//
// Each word passes through the accept in idle, a scan of every entry in index
// order through the shared key/rank comparator, and a write-back.
// in_ch.ready is high only while the sequencer is idle.
// The result register holds one word; if it is still full at write-back the
// sequencer waits until out_ch takes it.
// Reset clears valid bits, occupancy and the result valid flag, capacity to 8.
module lru_key_value_cache (
  input  logic          clk,
  input  logic          rst_n,
  lru_kv_in_if.sink     in_ch,
  lru_kv_out_if.source  out_ch,
  lru_kv_cfg_if.sink    cfg_ch
);

  lru_kv_pkg::state_t state_r;
  lru_kv_pkg::state_t state_nxt;

  logic [lru_kv_pkg::IDX_W-1:0]  idx_r;
  logic [lru_kv_pkg::IDX_W-1:0]  idx_nxt;
  logic [lru_kv_pkg::CAP_W-1:0]  cap_r;
  logic                          cmd_r;
  logic [lru_kv_pkg::DATA_W-1:0] key_r;
  logic [lru_kv_pkg::DATA_W-1:0] value_r;
  lru_kv_pkg::result_t           res_r;
  lru_kv_pkg::result_t           res_nxt;
  lru_kv_pkg::result_t           out_r;
  lru_kv_pkg::result_t           out_nxt;
  logic                          out_valid_r;
  logic                          out_valid_nxt;

  logic                          take_in;
  logic                          scan_clear;
  logic                          scan_step;
  lru_kv_pkg::entry_t            rd;
  lru_kv_pkg::scan_t             scan;
  lru_kv_pkg::wb_t               wb;
  lru_kv_pkg::wb_t               wb_dec;
  lru_kv_pkg::result_t           res_dec;
  logic [lru_kv_pkg::OCC_W-1:0]  occ;
  logic [lru_kv_pkg::CMP_W-1:0]  cap_ext;
  logic [lru_kv_pkg::CMP_W-1:0]  cap_sat;
  logic [lru_kv_pkg::CMP_W-1:0]  occ_ext;

  lru_kv_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_idx (idx_r),
    .rd     (rd),
    .wb     (wb),
    .occ    (occ)
  );

  lru_kv_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (scan_clear),
    .step  (scan_step),
    .idx   (idx_r),
    .key   (key_r),
    .rd    (rd),
    .res   (scan)
  );

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lru_kv_pkg::CAP_RESET;
    end else if (cfg_ch.valid) begin
      cap_r <= cfg_ch.data;
    end
  end

  always_comb begin
    cap_ext = lru_kv_pkg::CMP_W'(cap_r);
    occ_ext = lru_kv_pkg::CMP_W'(occ);
    priority if (cap_ext == '0) begin
      cap_sat = lru_kv_pkg::CMP_W'(1);
    end else if (cap_ext > lru_kv_pkg::CMP_W'(lru_kv_pkg::ENTRIES)) begin
      cap_sat = lru_kv_pkg::CMP_W'(lru_kv_pkg::ENTRIES);
    end else begin
      cap_sat = cap_ext;
    end
  end

  always_comb begin
    wb_dec          = '0;
    res_dec         = '0;
    wb_dec.key      = key_r;
    wb_dec.value    = value_r;
    wb_dec.wr_value = (cmd_r == lru_kv_pkg::CMD_PUT);
    if (scan.hit) begin
      wb_dec.en       = 1'b1;
      wb_dec.slot     = scan.hit_idx;
      wb_dec.old_rank = scan.hit_rank;
      res_dec.found   = 1'b1;
      if (cmd_r == lru_kv_pkg::CMD_GET) begin
        res_dec.read_value = scan.hit_value;
      end
    end else if (cmd_r == lru_kv_pkg::CMD_PUT) begin
      wb_dec.en     = 1'b1;
      wb_dec.insert = 1'b1;
      priority if (occ_ext < cap_sat && scan.free_found) begin
        wb_dec.slot    = scan.free_idx;
        wb_dec.occ_inc = 1'b1;
      end else if (scan.old_found) begin
        wb_dec.slot         = scan.old_idx;
        res_dec.evicted     = 1'b1;
        res_dec.evicted_key = scan.old_key;
      end else begin
        wb_dec.slot    = scan.free_idx;
        wb_dec.occ_inc = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lru_kv_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
    if (take_in) begin
      cmd_r   <= in_ch.cmd;
      key_r   <= in_ch.key;
      value_r <= in_ch.value;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    take_in       = 1'b0;
    scan_clear    = 1'b0;
    scan_step     = 1'b0;
    wb            = wb_dec;
    wb.en         = 1'b0;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      lru_kv_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          take_in    = 1'b1;
          scan_clear = 1'b1;
          idx_nxt    = '0;
          state_nxt  = lru_kv_pkg::S_SCAN;
        end
      end
      lru_kv_pkg::S_SCAN: begin
        scan_step = 1'b1;
        if (idx_r == lru_kv_pkg::IDX_LAST) begin
          state_nxt = lru_kv_pkg::S_WB;
        end else begin
          idx_nxt = idx_r + lru_kv_pkg::IDX_W'(1);
        end
      end
      lru_kv_pkg::S_WB: begin
        wb.en   = wb_dec.en;
        res_nxt = res_dec;
        if (!out_valid_r || out_ch.ready) begin
          out_nxt       = res_dec;
          out_valid_nxt = 1'b1;
          state_nxt     = lru_kv_pkg::S_IDLE;
        end else begin
          state_nxt = lru_kv_pkg::S_OUT;
        end
      end
      lru_kv_pkg::S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = lru_kv_pkg::S_IDLE;
        end
      end
    endcase
  end

  assign in_ch.ready        = (state_r == lru_kv_pkg::S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = out_r.found;
  assign out_ch.read_value  = out_r.read_value;
  assign out_ch.evicted     = out_r.evicted;
  assign out_ch.evicted_key = out_r.evicted_key;

endmodule

@@ rtl/core/lru_kv_chk.sv @@
// Port-level checker for the LRU key-value cache, bound to the top level.
// Depends on assert_macros.svh and lru_kv_pkg.
`include "assert_macros.svh"

module lru_kv_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_found,
  input logic [lru_kv_pkg::DATA_W-1:0] out_read_value,
  input logic                          out_evicted,
  input logic [lru_kv_pkg::DATA_W-1:0] out_evicted_key
);

  `ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result word dropped")
  `ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "ready after accept")
  `ASSERT_IMP(a_miss_reads_zero, clk, rst_n, out_valid && !out_found, out_read_value == '0, "miss value")
  `ASSERT_IMP(a_evict_is_miss, clk, rst_n, out_valid && out_evicted, !out_found, "evict on hit")
  `ASSERT_IMP(a_no_evict_key, clk, rst_n, out_valid && !out_evicted, out_evicted_key == '0, "stray key")

endmodule

bind lru_key_value_cache lru_kv_chk u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_found       (out_ch.found),
  .out_read_value  (out_ch.read_value),
  .out_evicted     (out_ch.evicted),
  .out_evicted_key (out_ch.evicted_key)
);
